>>> sv/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, types and helpers of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // gain is an unsigned fraction from 0 to one inclusive
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

    // divider sizes: denominator p_mid + R needs one bit above the data width
    localparam int DEN_W = DATA_W + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(GAIN_W + 1);

    // shared multiplier operand and product widths
    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic [7:0] REG_PROCESS_NOISE = 8'd0;
    localparam logic [7:0] REG_MEASURE_NOISE = 8'd1;

    // divider request
    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } div_rsp_t;

    // clamp a wide signed value to the signed data range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sd2147483647;
        min_v = -64'sd2147483648;
        if (v > max_v)
            sat32 = DATA_W'(max_v);
        else if (v < min_v)
            sat32 = DATA_W'(min_v);
        else
            sat32 = DATA_W'(v);
    endfunction

endpackage

>>> sv/skf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_divider
// Restoring radix-2 divider for the gain: quotient of dividend * 2^FRAC_BITS
// over divisor, one quotient bit per cycle, dividend not above divisor.
// ----------------------------------------------------------------------------
module skf_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  skf_pkg::div_req_t req,
    output skf_pkg::div_rsp_t rsp
);

    logic [skf_pkg::REM_W-1:0]  rem_reg;
    logic [skf_pkg::REM_W-1:0]  rem_next;
    logic [skf_pkg::DEN_W-1:0]  den_reg;
    logic [skf_pkg::GAIN_W-1:0] quo_reg;
    logic [skf_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [skf_pkg::REM_W-1:0]  den_ext;
    logic [skf_pkg::REM_W-1:0]  diff;
    logic [skf_pkg::REM_W-1:0]  part;
    logic                       ge;

    // one compare and subtract step
    always_comb
    begin
        den_ext  = {1'b0, den_reg};
        ge       = (rem_reg >= den_ext);
        diff     = rem_reg - den_ext;
        part     = ge ? diff : rem_reg;
        rem_next = {part[skf_pkg::REM_W-2:0], 1'b0};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= skf_pkg::CNT_W'(skf_pkg::GAIN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == skf_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, req.dividend};
            den_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[skf_pkg::GAIN_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sv/skf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_mul
// Shared signed multiplier with a registered product, used for both the
// estimate and the covariance update.
// ----------------------------------------------------------------------------
module skf_mul
(
    input  logic                               clk,
    input  logic signed [skf_pkg::MUL_A_W-1:0] a,
    input  logic signed [skf_pkg::MUL_B_W-1:0] b,
    output logic signed [skf_pkg::PROD_W-1:0]  prod
);

    logic signed [skf_pkg::PROD_W-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= skf_pkg::PROD_W'(a) * skf_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

>>> sv/scalar_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in signed Q16.16 with a shared divider and
// a shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one measurement item; m_* channel returns one estimate
//   item for each. s_tready is high only while the sequencer is idle, so one
//   item is worked on at a time.
//   From acceptance to the estimate on m_tdata an item passes S_START, which
//   starts the gain divider, S_DIV for its GAIN_W (17) radix-2 steps and its
//   done flag, S_MUL1 to S_MUL3 through the shared multiplier and S_DONE,
//   which loads the output register. When the predicted covariance is not
//   positive the divider is skipped and S_DIV with it.
//   s_tready returns as the estimate is loaded, so a new item is accepted
//   only after the last one has reached the output register.
//   The estimate waits in an output register; a stalled receiver holds the
//   next item in its last step until the register is free.
//   cfg_* writes process_noise (index 0) or measure_noise (index 1); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
//   Reset clears estimate and covariance to zero and loads the noise
//   registers with 655 and 65536.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
(
    input  logic        clk,
    input  logic        rst_n,
    // measurement item: [31:0] measurement
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // estimate item: [31:0] estimate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [31:0]                       q_reg;
    logic [31:0]                       r_reg;
    logic signed [31:0]                est_reg;
    logic signed [31:0]                cov_reg;
    logic signed [31:0]                meas_reg;
    logic signed [31:0]                pmid_reg;
    logic [skf_pkg::GAIN_W-1:0]        gain_reg;
    logic signed [31:0]                xnew_reg;
    logic signed [31:0]                pnew_reg;
    logic                              out_valid_reg;
    logic [31:0]                       out_data_reg;

    logic                              in_accept;
    logic                              out_free;
    logic signed [63:0]                pmid_wide;
    logic signed [31:0]                pmid_sat;
    logic signed [32:0]                innov;
    logic signed [skf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [skf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [skf_pkg::PROD_W-1:0]  prod;
    logic signed [skf_pkg::PROD_W-1:0]  prod_scaled;
    logic signed [63:0]                xnew_wide;
    logic signed [63:0]                pnew_wide;
    skf_pkg::div_req_t                 div_req;
    skf_pkg::div_rsp_t                 div_rsp;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // predicted covariance, saturated
    always_comb
    begin
        pmid_wide = 64'(cov_reg) + 64'(signed'({1'b0, q_reg}));
        pmid_sat  = skf_pkg::sat32(pmid_wide);
    end

    // gain divider request
    always_comb
    begin
        div_req.start    = (state_reg == S_START) && !pmid_reg[31] && (pmid_reg != '0);
        div_req.dividend = skf_pkg::DEN_W'(unsigned'(pmid_reg));
        div_req.divisor  = skf_pkg::DEN_W'(unsigned'(pmid_reg)) + skf_pkg::DEN_W'(r_reg);
    end

    skf_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // multiplier operands: innovation times gain, then covariance times one minus gain
    always_comb
    begin
        innov = 33'(meas_reg) - 33'(est_reg);
        if (state_reg == S_MUL1)
        begin
            mul_a = skf_pkg::MUL_A_W'(innov);
            mul_b = signed'({1'b0, gain_reg});
        end
        else
        begin
            mul_a = skf_pkg::MUL_A_W'(pmid_reg);
            mul_b = signed'({1'b0, skf_pkg::GAIN_ONE - gain_reg});
        end
    end

    skf_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // scale products back, rounding toward minus infinity
    always_comb
    begin
        prod_scaled = prod >>> skf_pkg::FRAC_BITS;
        xnew_wide   = 64'(est_reg) + 64'(prod_scaled);
        pnew_wide   = 64'(prod_scaled);
    end

    // sequencer, state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_reg         <= 32'd655;
            r_reg         <= 32'd65536;
            est_reg       <= '0;
            cov_reg       <= '0;
            meas_reg      <= '0;
            pmid_reg      <= '0;
            gain_reg      <= '0;
            xnew_reg      <= '0;
            pnew_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    skf_pkg::REG_PROCESS_NOISE: q_reg <= cfg_data;
                    skf_pkg::REG_MEASURE_NOISE: r_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the last step loads the register itself
            if (m_tready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        meas_reg  <= signed'(s_tdata);
                        pmid_reg  <= pmid_sat;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    gain_reg <= '0;
                    if (div_req.start)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_MUL1;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        gain_reg  <= div_rsp.quotient;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    xnew_reg  <= skf_pkg::sat32(xnew_wide);
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    pnew_reg  <= skf_pkg::sat32(pnew_wide);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        est_reg       <= xnew_reg;
                        cov_reg       <= pnew_reg;
                        out_data_reg  <= unsigned'(xnew_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // gain never exceeds one once the multiplies start
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1) |-> (gain_reg <= skf_pkg::GAIN_ONE))
        else $error("gain above one");

    // covariance stays non-negative
    a_cov_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !cov_reg[31])
        else $error("negative covariance");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside division step");

    // a new estimate appears only from the last step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("estimate item without finished update");

endmodule
